/* hdl/watchpoint_table_dr7_encoder_unit_macros.svh */
// Assertion macros shared by the watchpoint table RTL.
`ifndef WATCHPOINT_TABLE_DR7_ENCODER_UNIT_MACROS_SVH
`define WATCHPOINT_TABLE_DR7_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define WP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/wpdr7_pkg.sv */
// Package: status and action codes, field widths and DR7 code tables.
package wpdr7_pkg;

	localparam int SLOTS_DEF  = 4;
	localparam int SLOTS_MAX  = 4;
	localparam int SLOT_IDX_W = 2;
	localparam int ADDR_W     = 64;
	localparam int LEN_W      = 4;
	localparam int ACC_W      = 3;
	localparam int ACT_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 3;
	localparam int DR7_W      = 32;
	localparam int DR7_RW_BASE = 16;

	// Request actions
	localparam logic [ACT_W-1:0] ACT_SET       = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_ATTACHED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PARAM        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd4;

	// DR7 access code: exec 0, write 1, read and read-write 3
	function automatic logic [1:0] rw_code(input logic [ACC_W-1:0] acc);
		logic [1:0] code;
		case (acc)
			3'd0: code = 2'd0;
			3'd1: code = 2'd1;
			default: code = 2'd3;
		endcase
		return code;
	endfunction

	// DR7 length code: 1 byte 0, 2 bytes 1, 4 bytes 3, 8 bytes 2
	function automatic logic [1:0] len_code(input logic [LEN_W-1:0] len);
		logic [1:0] code;
		case (len)
			4'd1: code = 2'd0;
			4'd2: code = 2'd1;
			4'd4: code = 2'd3;
			default: code = 2'd2;
		endcase
		return code;
	endfunction

endpackage

/* hdl/watchpoint_table_dr7_encoder_unit.sv */
// Top level: watchpoint slot table with DR7 control word encoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  request  | in_valid / in_stall    | action, address, length, access_type
//  result   | out_valid / out_stall  | status, slot_index, cleared_count, dr7
//  config   | cfg_valid / cfg_ready  | cfg_data (attached)
//
//  One request per cycle while the result is not stalled: a transfer lands in the
//  input register, then the slot compare, free-slot priority encoder and DR7 encode
//  settle into the result register.
//  The table is updated on the same edge that loads the result register.
//  arst_n clears the table valid bits, the attached flag and both valid flags.
//  A stalled result holds the result register; the input register then fills
//  and in_stall rises until the result is taken.
`include "watchpoint_table_dr7_encoder_unit_macros.svh"

module watchpoint_table_dr7_encoder_unit #(
	parameter int SLOTS = wpdr7_pkg::SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data,
	// request
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [wpdr7_pkg::ACT_W-1:0]        action,
	input  logic [wpdr7_pkg::ADDR_W-1:0]       address,
	input  logic [wpdr7_pkg::LEN_W-1:0]        length,
	input  logic [wpdr7_pkg::ACC_W-1:0]        access_type,
	// result
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [wpdr7_pkg::STATUS_W-1:0]     status,
	output logic [wpdr7_pkg::SLOT_IDX_W-1:0]   slot_index,
	output logic [wpdr7_pkg::COUNT_W-1:0]      cleared_count,
	output logic [wpdr7_pkg::DR7_W-1:0]       dr7
);
	import wpdr7_pkg::*;

	// Configuration register
	logic attached_q;

	// Input register
	logic                  valid_s1;
	logic [ACT_W-1:0]      action_s1;
	logic [ADDR_W-1:0]     address_s1;
	logic [LEN_W-1:0]      length_s1;
	logic [ACC_W-1:0]      access_s1;

	// Slot table
	logic [SLOTS-1:0]      slot_valid_q;
	logic [ADDR_W-1:0]     slot_addr_q [SLOTS];
	logic [1:0]            slot_len_q  [SLOTS];
	logic [1:0]            slot_rw_q   [SLOTS];

	// Result register
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [SLOT_IDX_W-1:0] slot_q;
	logic [COUNT_W-1:0]    count_q;
	logic [DR7_W-1:0]      dr7_q;

	// Request logic
	logic                  advance;
	logic [SLOTS-1:0]      hit_vec;
	logic                  hit_any;
	logic [SLOT_IDX_W-1:0] hit_idx;
	logic                  free_any;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic                  param_ok;
	logic [COUNT_W-1:0]    valid_cnt;
	logic                  do_set;
	logic                  do_clear;
	logic                  do_clear_all;
	logic [STATUS_W-1:0]   status_d;
	logic [SLOT_IDX_W-1:0] slot_d;
	logic [COUNT_W-1:0]    count_d;
	logic [SLOTS-1:0]      valid_d;
	logic [1:0]            new_len;
	logic [1:0]            new_rw;
	logic [DR7_W-1:0]      dr7_d;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			attached_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1  <= action;
			address_s1 <= address;
			length_s1  <= length;
			access_s1  <= access_type;
		end
	end

	// Address compare, lowest free slot and occupancy count
	always_comb begin
		hit_any   = 1'b0;
		hit_idx   = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		valid_cnt = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			hit_vec[i] = slot_valid_q[i] && (slot_addr_q[i] == address_s1);
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = SLOT_IDX_W'(i);
			end
			if (!slot_valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_IDX_W'(i);
			end
			valid_cnt = valid_cnt + {{(COUNT_W-1){1'b0}}, slot_valid_q[i]};
		end
	end

	assign param_ok = ((length_s1 == 4'd1) || (length_s1 == 4'd2) ||
	                   (length_s1 == 4'd4) || (length_s1 == 4'd8)) &&
	                  (access_s1 <= 3'd3);
	assign new_len  = len_code(length_s1);
	assign new_rw   = rw_code(access_s1);

	// Request decode
	always_comb begin
		status_d     = ST_OK;
		slot_d       = '0;
		count_d      = '0;
		do_set       = 1'b0;
		do_clear     = 1'b0;
		do_clear_all = 1'b0;
		if (!attached_q) begin
			status_d = ST_NOT_ATTACHED;
		end else begin
			case (action_s1)
				ACT_SET: begin
					if (!param_ok || hit_any) begin
						status_d = ST_PARAM;
					end else if (!free_any) begin
						status_d = ST_NO_SLOT;
					end else begin
						do_set = 1'b1;
						slot_d = free_idx;
					end
				end
				ACT_CLEAR: begin
					if (!hit_any) begin
						status_d = ST_NOT_FOUND;
					end else begin
						do_clear = 1'b1;
						slot_d   = hit_idx;
					end
				end
				ACT_CLEAR_ALL: begin
					do_clear_all = 1'b1;
					count_d      = valid_cnt;
				end
				default: begin
					status_d = ST_PARAM;
				end
			endcase
		end
	end

	// Table after the request, and its DR7 encoding
	always_comb begin
		valid_d = slot_valid_q;
		dr7_d   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (do_clear_all || (do_clear && slot_d == SLOT_IDX_W'(i))) begin
				valid_d[i] = 1'b0;
			end
			if (do_set && slot_d == SLOT_IDX_W'(i)) begin
				valid_d[i] = 1'b1;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_d[i]) begin
				dr7_d[2*i]   = 1'b1;
				dr7_d[2*i+1] = 1'b1;
				if (do_set && slot_d == SLOT_IDX_W'(i)) begin
					dr7_d[DR7_RW_BASE+4*i +: 2]   = new_rw;
					dr7_d[DR7_RW_BASE+4*i+2 +: 2] = new_len;
				end else begin
					dr7_d[DR7_RW_BASE+4*i +: 2]   = slot_rw_q[i];
					dr7_d[DR7_RW_BASE+4*i+2 +: 2] = slot_len_q[i];
				end
			end
		end
	end

	// Table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (advance) begin
			slot_valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (advance && do_set && slot_d == SLOT_IDX_W'(i)) begin
				slot_addr_q[i] <= address_s1;
				slot_len_q[i]  <= new_len;
				slot_rw_q[i]   <= new_rw;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			count_q  <= count_d;
			dr7_q    <= dr7_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_index    = slot_q;
	assign cleared_count = count_q;
	assign dr7           = dr7_q;

	// Checks
	`WP_ASSERT_NOW(a_fail_fields_zero, clk, arst_n, out_valid_q && (status_q != ST_OK), (slot_q == '0) && (count_q == '0), "failed request carries slot or count")
	`WP_ASSERT_NEXT(a_detached_no_change, clk, arst_n, advance && !attached_q, $stable(slot_valid_q), "table changed while detached")
	`WP_ASSERT_NEXT(a_clear_all_empties, clk, arst_n, advance && attached_q && (action_s1 == ACT_CLEAR_ALL), (slot_valid_q == '0) && (dr7_q == '0), "clear all left a slot valid")
	`WP_ASSERT_NOW(a_set_needs_free, clk, arst_n, advance && do_set, !slot_valid_q[slot_d], "set picked an occupied slot")

endmodule
